### rtl/cam_pkg.sv
// shared types, codes and helper functions for the command authority mode manager
package cam_pkg;

	typedef enum logic [1:0] {
		MODE_MANUAL     = 2'd0,
		MODE_STANDBY    = 2'd1,
		MODE_REMOTE     = 2'd2,
		MODE_AUTONOMOUS = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		CMD_BEGIN_STEP = 2'd0,
		CMD_END_STEP   = 2'd1,
		CMD_SET_MODE   = 2'd2,
		CMD_ADMIT      = 2'd3
	} cmd_t;

	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 16;
	localparam logic [CFG_INDEX_W-1:0] REG_IDLE_REVERT    = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_ALLOW_IMPLICIT = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_OUT_OF_MODE    = 2'd2;

	localparam logic [15:0] IDLE_REVERT_RESET = 16'd50;
	localparam logic [15:0] IDLE_MAX          = 16'hffff;

	localparam int IN_TDATA_W  = 8;
	localparam int OUT_TDATA_W = 80;
	localparam int EPOCH_W     = 64;

	typedef struct packed {
		cmd_t        command;
		logic        manual_engaged;
		logic        local_active;
		logic        remote_active;
		mode_t       requested_mode;
		logic        is_local_class;
	} item_t;

	typedef struct packed {
		logic [EPOCH_W-1:0] authority_epoch;
		logic               reject_remote;
		logic               reject_local;
		logic               would_admit_remote;
		logic               would_admit_local;
		logic               admitted;
		logic               command_accepted;
		logic               mode_changed;
		mode_t              current_mode;
	} result_t;

	function automatic logic admissible(mode_t mode, logic is_local, logic allow_implicit);
		logic ok;
		case (mode)
			MODE_STANDBY:    ok = allow_implicit;
			MODE_REMOTE:     ok = ~is_local;
			MODE_AUTONOMOUS: ok = is_local | allow_implicit;
			default:         ok = 1'b0;
		endcase
		return ok;
	endfunction

	function automatic logic rejected(mode_t mode, logic is_local, logic allow_implicit,
			logic out_of_mode_fails);
		return (mode == MODE_MANUAL) |
			(out_of_mode_fails & ~admissible(mode, is_local, allow_implicit));
	endfunction

endpackage

### rtl/command_authority_mode_manager_top.sv
// top level of the command authority mode manager
//
// channel   direction  tdata                              tuser
// s_axis    in         item flags and requested mode      command
// m_axis    out        mode, flags, 64-bit authority epoch  -
// cfg       in         write-only register port, no handshake
//
// cycles: one transaction in and one result out per clock when both sides flow;
//   a transaction passes through the input register and then the result register,
//   with the mode and counter update done in the single pass between them
// reset: arst_n clears handshake state, mode (standby), flags, idle timing,
//   epoch and the configuration registers to their defaults
// stalls: a held result does not block the input register from filling; the
//   input register drains as soon as the result register frees up
module command_authority_mode_manager_top import cam_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	// fields from bit 0: manual_engaged, local_active, remote_active,
	// requested_mode[1:0], is_local_class, zero pad
	input  logic [IN_TDATA_W-1:0]  s_tdata,
	// fields from bit 0: command[1:0]
	input  logic [1:0]             s_tuser,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	// fields from bit 0: current_mode[1:0], mode_changed, command_accepted,
	// admitted, would_admit_local, would_admit_remote, reject_local,
	// reject_remote, authority_epoch[63:0], zero pad
	output logic [OUT_TDATA_W-1:0] m_tdata,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	localparam int RESULT_W = $bits(result_t);

	item_t   in_item;
	item_t   item_s1;
	logic    item_valid_s1;
	logic    fire;
	logic    out_free;
	result_t result;
	result_t result_q;

	// unpack the slave-side transaction
	always_comb begin
		in_item.command        = cmd_t'(s_tuser);
		in_item.manual_engaged = s_tdata[0];
		in_item.local_active   = s_tdata[1];
		in_item.remote_active  = s_tdata[2];
		in_item.requested_mode = mode_t'(s_tdata[4:3]);
		in_item.is_local_class = s_tdata[5];
	end

	cam_in_stage u_in (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (s_tvalid),
		.in_ready     (s_tready),
		.in_item      (in_item),
		.out_free     (out_free),
		.item_valid_s1(item_valid_s1),
		.item_s1      (item_s1),
		.fire         (fire)
	);

	// state only advances on fire, so item_valid_s1 already gates it
	cam_mode_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.fire     (fire & item_valid_s1),
		.item_s1  (item_s1),
		.result   (result)
	);

	cam_out_stage u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.fire     (fire),
		.result   (result),
		.out_free (out_free),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.result_q (result_q)
	);

	// result struct is declared with current_mode in its lowest bits
	assign m_tdata = {{(OUT_TDATA_W - RESULT_W){1'b0}}, result_q};

endmodule

### rtl/cam_in_stage.sv
// input register stage: captures one transaction from the slave side
module cam_in_stage import cam_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	input  item_t in_item,
	input  logic  out_free,
	output logic  item_valid_s1,
	output item_t item_s1,
	output logic  fire
);

	logic valid_s1;

	assign fire          = valid_s1 & out_free;
	assign in_ready      = ~valid_s1 | out_free;
	assign item_valid_s1 = valid_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// payload needs no reset
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_item;
		end
	end

endmodule

### rtl/cam_mode_core.sv
// configuration registers, mode state and the single-pass step logic
module cam_mode_core import cam_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	input  logic                   fire,
	input  item_t                  item_s1,
	output result_t                result
);

	logic [15:0]        idle_revert_q;
	logic               allow_implicit_q;
	logic               out_of_mode_q;

	mode_t              mode_q, n_mode;
	logic               init_q, n_init;
	logic               expl_q, n_expl;
	logic               idle_valid_q, n_idle_valid;
	logic [15:0]        idle_cnt_q, n_idle_cnt;
	logic [EPOCH_W-1:0] epoch_q, n_epoch;

	logic               changed, accepted, admit;
	logic               revertible, busy;
	logic [15:0]        cnt_after;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_revert_q    <= IDLE_REVERT_RESET;
			allow_implicit_q <= 1'b1;
			out_of_mode_q    <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_IDLE_REVERT:    idle_revert_q    <= cfg_data;
				REG_ALLOW_IMPLICIT: allow_implicit_q <= cfg_data[0];
				REG_OUT_OF_MODE:    out_of_mode_q    <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		n_mode       = mode_q;
		n_init       = init_q;
		n_expl       = expl_q;
		n_idle_valid = idle_valid_q;
		n_idle_cnt   = idle_cnt_q;
		n_epoch      = epoch_q;
		changed      = 1'b0;
		accepted     = 1'b0;
		admit        = 1'b0;
		revertible   = ((mode_q == MODE_REMOTE) | (mode_q == MODE_AUTONOMOUS)) & ~expl_q;
		busy         = (mode_q == MODE_REMOTE) ? item_s1.remote_active : item_s1.local_active;
		if (!idle_valid_q) begin
			cnt_after = '0;
		end else if (idle_cnt_q != IDLE_MAX) begin
			cnt_after = idle_cnt_q + 16'd1;
		end else begin
			cnt_after = idle_cnt_q;
		end

		case (item_s1.command)
			CMD_BEGIN_STEP: begin
				if (!init_q) begin
					// first begin step announces the mode even if unchanged
					n_init  = 1'b1;
					n_mode  = item_s1.manual_engaged ? MODE_MANUAL : MODE_STANDBY;
					n_expl  = 1'b0;
					changed = 1'b1;
				end else if (item_s1.manual_engaged && mode_q != MODE_MANUAL) begin
					n_epoch      = epoch_q + 64'd1;
					n_mode       = MODE_MANUAL;
					n_expl       = 1'b0;
					n_idle_valid = 1'b0;
					n_idle_cnt   = '0;
					changed      = 1'b1;
				end else if (!item_s1.manual_engaged && mode_q == MODE_MANUAL) begin
					n_mode       = MODE_STANDBY;
					n_expl       = 1'b0;
					n_idle_valid = 1'b0;
					n_idle_cnt   = '0;
					changed      = 1'b1;
				end
			end
			CMD_END_STEP: begin
				if (!revertible || busy) begin
					n_idle_valid = 1'b0;
					n_idle_cnt   = '0;
				end else if (cnt_after >= idle_revert_q) begin
					// idle long enough: implicit fall back to standby
					n_mode       = MODE_STANDBY;
					n_expl       = 1'b0;
					n_idle_valid = 1'b0;
					n_idle_cnt   = '0;
					changed      = 1'b1;
				end else begin
					n_idle_valid = 1'b1;
					n_idle_cnt   = cnt_after;
				end
			end
			CMD_SET_MODE: begin
				if (mode_q != MODE_MANUAL && item_s1.requested_mode != MODE_MANUAL) begin
					n_epoch      = epoch_q + 64'd1;
					n_mode       = item_s1.requested_mode;
					n_expl       = 1'b1;
					n_idle_valid = 1'b0;
					n_idle_cnt   = '0;
					changed      = (mode_q != item_s1.requested_mode);
					accepted     = 1'b1;
				end
			end
			CMD_ADMIT: begin
				case (mode_q)
					MODE_STANDBY: begin
						if (allow_implicit_q) begin
							n_mode       = item_s1.is_local_class ? MODE_AUTONOMOUS
								: MODE_REMOTE;
							n_expl       = 1'b0;
							n_idle_valid = 1'b0;
							n_idle_cnt   = '0;
							changed      = 1'b1;
							admit        = 1'b1;
						end
					end
					MODE_REMOTE: begin
						admit = ~item_s1.is_local_class;
					end
					MODE_AUTONOMOUS: begin
						if (item_s1.is_local_class) begin
							admit = 1'b1;
						end else if (allow_implicit_q) begin
							n_mode       = MODE_REMOTE;
							n_expl       = 1'b0;
							n_idle_valid = 1'b0;
							n_idle_cnt   = '0;
							changed      = 1'b1;
							admit        = 1'b1;
						end
					end
					default: ;
				endcase
			end
			default: ;
		endcase

		result.current_mode       = n_mode;
		result.mode_changed       = changed;
		result.command_accepted   = accepted;
		result.admitted           = admit;
		result.would_admit_local  = admissible(n_mode, 1'b1, allow_implicit_q);
		result.would_admit_remote = admissible(n_mode, 1'b0, allow_implicit_q);
		result.reject_local       = rejected(n_mode, 1'b1, allow_implicit_q, out_of_mode_q);
		result.reject_remote      = rejected(n_mode, 1'b0, allow_implicit_q, out_of_mode_q);
		result.authority_epoch    = n_epoch;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= MODE_STANDBY;
			init_q       <= 1'b0;
			expl_q       <= 1'b0;
			idle_valid_q <= 1'b0;
			idle_cnt_q   <= '0;
			epoch_q      <= '0;
		end else if (fire) begin
			mode_q       <= n_mode;
			init_q       <= n_init;
			expl_q       <= n_expl;
			idle_valid_q <= n_idle_valid;
			idle_cnt_q   <= n_idle_cnt;
			epoch_q      <= n_epoch;
		end
	end

endmodule

### rtl/cam_out_stage.sv
// result register: holds one result until the master side takes it
module cam_out_stage import cam_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    fire,
	input  result_t result,
	output logic    out_free,
	output logic    out_valid,
	input  logic    out_ready,
	output result_t result_q
);

	logic valid_q;

	assign out_valid = valid_q;
	assign out_free  = ~valid_q | out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (out_free) begin
			valid_q <= fire;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			result_q <= result;
		end
	end

endmodule

### rtl/cam_checker.sv
// port-level checker for the command authority mode manager, bound to the top level
module cam_checker import cam_pkg::*; (
	input logic                   clk,
	input logic                   arst_n,
	input logic [OUT_TDATA_W-1:0] m_tdata,
	input logic                   m_tvalid,
	input logic                   m_tready
);

	// a stalled result holds
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// an accepted mode command never leaves the block in manual
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[3] |-> m_tdata[1:0] != MODE_MANUAL)
		else $error("mode command accepted into manual");

	// manual rejects both classes at validation
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[1:0] == MODE_MANUAL |-> m_tdata[7] && m_tdata[8])
		else $error("manual mode does not reject");

	// an admitted request always ends in remote or autonomous
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[4] |->
			m_tdata[1:0] == MODE_REMOTE || m_tdata[1:0] == MODE_AUTONOMOUS)
		else $error("admission outside a serving mode");

	// remote mode serves the remote class only
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[1:0] == MODE_REMOTE |-> m_tdata[6] && !m_tdata[5])
		else $error("remote mode admissibility wrong");

endmodule

bind command_authority_mode_manager_top cam_checker u_cam_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.m_tdata (m_tdata),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready)
);

### bench/testbench.sv
// self-checking testbench for the command authority mode manager top level
module testbench;
	import cam_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	// config index that decodes to no register, writes to it must be dropped
	localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;
	localparam int PHASES = 6;
	localparam int ITEMS_PER_PHASE = 135;
	localparam int HOLD_CYCLES = 60;
	localparam int SETTLE_CYCLES = 4;

	typedef struct {
		item_t   stim;
		logic    pinned;
		result_t want;
	} step_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic [IN_TDATA_W-1:0] s_tdata = '0;
	logic [1:0] s_tuser = '0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// hand-typed expectation that travels beside the transaction on the wire
	logic item_pinned = 1'b0;
	result_t item_want = '0;

	// idling percentages, set by the stimulus process
	int send_gap_pct = 0;
	int recv_stall_pct = 0;
	// bumped by the stimulus to ask the receiver for a long hold-off
	int hold_req = 0;

	int err_count = 0;
	int result_count = 0;

	// expected results in acceptance order
	result_t pending_results[$];

	// predictor copy of configuration and state
	logic [15:0] idle_limit = IDLE_REVERT_RESET;
	logic allow_implicit = 1'b1;
	logic out_of_mode_fail = 1'b0;
	mode_t cur_mode = MODE_STANDBY;
	logic started = 1'b0;
	logic by_command = 1'b0;
	logic idle_run = 1'b0;
	logic [15:0] idle_cnt = '0;
	logic [EPOCH_W-1:0] epoch = '0;

	command_authority_mode_manager_top u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.m_tdata   (m_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #2 clk = ~clk;

	// overall watchdog, far beyond the slowest legal run
	initial begin
		#400000;
		$display("command_authority_mode_manager_top test failed");
		$finish;
	end

	task automatic report(input string msg);
		$display("ERROR result %0d: %s", result_count, msg);
		err_count++;
	endtask

	// whether a class would be admitted in the given mode
	function automatic logic class_ok(mode_t m, logic is_local);
		case (m)
			MODE_STANDBY:    return allow_implicit;
			MODE_REMOTE:     return !is_local;
			MODE_AUTONOMOUS: return is_local || allow_implicit;
			default:         return 1'b0;
		endcase
	endfunction

	// any transition request resets idle timing and records how it was entered
	function automatic logic enter_mode(mode_t next, logic commanded);
		by_command = commanded;
		idle_run = 1'b0;
		idle_cnt = '0;
		if (cur_mode == next)
			return 1'b0;
		cur_mode = next;
		return 1'b1;
	endfunction

	// next mode, flags and epoch for one accepted transaction
	function automatic result_t advance_authority(item_t it);
		result_t r;
		logic chg;
		logic acc;
		logic adm;
		logic revertible;
		logic busy;
		chg = 1'b0;
		acc = 1'b0;
		adm = 1'b0;
		case (it.command)
			CMD_BEGIN_STEP: begin
				if (!started) begin
					// first begin step announces the initial mode, epoch untouched
					started = 1'b1;
					cur_mode = it.manual_engaged ? MODE_MANUAL : MODE_STANDBY;
					by_command = 1'b0;
					chg = 1'b1;
				end else if (it.manual_engaged && cur_mode != MODE_MANUAL) begin
					epoch++;
					chg = enter_mode(MODE_MANUAL, 1'b0);
				end else if (!it.manual_engaged && cur_mode == MODE_MANUAL) begin
					chg = enter_mode(MODE_STANDBY, 1'b0);
				end
			end
			CMD_END_STEP: begin
				revertible = (cur_mode == MODE_REMOTE || cur_mode == MODE_AUTONOMOUS) &&
					!by_command;
				busy = (cur_mode == MODE_REMOTE) ? it.remote_active : it.local_active;
				if (!revertible || busy) begin
					idle_run = 1'b0;
					idle_cnt = '0;
				end else begin
					if (!idle_run) begin
						idle_run = 1'b1;
						idle_cnt = '0;
					end else if (idle_cnt != IDLE_MAX) begin
						idle_cnt++;
					end
					if (idle_cnt >= idle_limit)
						chg = enter_mode(MODE_STANDBY, 1'b0);
				end
			end
			CMD_SET_MODE: begin
				if (cur_mode != MODE_MANUAL && it.requested_mode != MODE_MANUAL) begin
					epoch++;
					chg = enter_mode(it.requested_mode, 1'b1);
					acc = 1'b1;
				end
			end
			default: begin
				case (cur_mode)
					MODE_STANDBY: begin
						if (allow_implicit) begin
							if (it.is_local_class)
								chg = enter_mode(MODE_AUTONOMOUS, 1'b0);
							else
								chg = enter_mode(MODE_REMOTE, 1'b0);
							adm = 1'b1;
						end
					end
					MODE_REMOTE: adm = !it.is_local_class;
					MODE_AUTONOMOUS: begin
						if (it.is_local_class) begin
							adm = 1'b1;
						end else if (allow_implicit) begin
							chg = enter_mode(MODE_REMOTE, 1'b0);
							adm = 1'b1;
						end
					end
					default: ;
				endcase
			end
		endcase
		r.current_mode = cur_mode;
		r.mode_changed = chg;
		r.command_accepted = acc;
		r.admitted = adm;
		r.would_admit_local = class_ok(cur_mode, 1'b1);
		r.would_admit_remote = class_ok(cur_mode, 1'b0);
		r.reject_local = (cur_mode == MODE_MANUAL) ||
			(out_of_mode_fail && !class_ok(cur_mode, 1'b1));
		r.reject_remote = (cur_mode == MODE_MANUAL) ||
			(out_of_mode_fail && !class_ok(cur_mode, 1'b0));
		r.authority_epoch = epoch;
		return r;
	endfunction

	// input side: values are stable at the falling edge, the handshake
	// completes at the next rising edge
	always @(negedge clk) begin
		item_t it;
		result_t r;
		if (arst_n && s_tvalid && s_tready) begin
			it.command = cmd_t'(s_tuser);
			it.manual_engaged = s_tdata[0];
			it.local_active = s_tdata[1];
			it.remote_active = s_tdata[2];
			it.requested_mode = mode_t'(s_tdata[4:3]);
			it.is_local_class = s_tdata[5];
			r = advance_authority(it);
			pending_results.push_back(item_pinned ? item_want : r);
		end
	end

	// output side: compare every field with the oldest expectation
	always @(negedge clk) begin
		result_t got;
		result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			result_count++;
			got = m_tdata[$bits(result_t)-1:0];
			if (pending_results.size() == 0) begin
				report($sformatf("unexpected transaction %h", m_tdata));
			end else begin
				want = pending_results.pop_front();
				if (got.current_mode !== want.current_mode)
					report($sformatf("current_mode %0d, want %0d",
						got.current_mode, want.current_mode));
				if (got.mode_changed !== want.mode_changed)
					report($sformatf("mode_changed %b, want %b",
						got.mode_changed, want.mode_changed));
				if (got.command_accepted !== want.command_accepted)
					report($sformatf("command_accepted %b, want %b",
						got.command_accepted, want.command_accepted));
				if (got.admitted !== want.admitted)
					report($sformatf("admitted %b, want %b", got.admitted, want.admitted));
				if (got.would_admit_local !== want.would_admit_local)
					report($sformatf("would_admit_local %b, want %b",
						got.would_admit_local, want.would_admit_local));
				if (got.would_admit_remote !== want.would_admit_remote)
					report($sformatf("would_admit_remote %b, want %b",
						got.would_admit_remote, want.would_admit_remote));
				if (got.reject_local !== want.reject_local)
					report($sformatf("reject_local %b, want %b",
						got.reject_local, want.reject_local));
				if (got.reject_remote !== want.reject_remote)
					report($sformatf("reject_remote %b, want %b",
						got.reject_remote, want.reject_remote));
				if (got.authority_epoch !== want.authority_epoch)
					report($sformatf("authority_epoch %0h, want %0h",
						got.authority_epoch, want.authority_epoch));
			end
			if (m_tdata[OUT_TDATA_W-1:$bits(result_t)] !== '0)
				report($sformatf("pad bits %b not zero", m_tdata[OUT_TDATA_W-1:$bits(result_t)]));
		end
	end

	// receiver: random stalls, plus a long counted hold-off on request so the
	// two internal stages fill and the input side backs up
	initial begin
		int hold_left;
		int hold_seen;
		hold_left = 0;
		hold_seen = 0;
		forever begin
			@(posedge clk);
			if (hold_req != hold_seen) begin
				hold_seen = hold_req;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	// drive one transaction; entered and left right after a rising edge
	task automatic offer(input item_t it, input logic pin, input result_t want);
		logic taken;
		if ($urandom_range(99) < send_gap_pct) begin
			s_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_gap_pct);
		end
		s_tvalid <= 1'b1;
		s_tuser <= it.command;
		s_tdata <= {2'b00, it.is_local_class, it.requested_mode, it.remote_active,
			it.local_active, it.manual_engaged};
		item_pinned <= pin;
		item_want <= want;
		do begin
			@(negedge clk);
			taken = s_tready;
			@(posedge clk);
		end while (!taken);
	endtask

	// stop offering and wait for every outstanding result, then let the
	// two pipeline stages settle
	task automatic drain();
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// register write; the block only sees it while idle, so the predictor
	// copy is updated right away
	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [15:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		case (idx)
			REG_IDLE_REVERT:    idle_limit = value;
			REG_ALLOW_IMPLICIT: allow_implicit = value[0];
			REG_OUT_OF_MODE:    out_of_mode_fail = value[0];
			default: ;
		endcase
	endtask

	function automatic item_t mk(cmd_t c, logic m, logic la, logic ra, mode_t q, logic cl);
		item_t it;
		it.command = c;
		it.manual_engaged = m;
		it.local_active = la;
		it.remote_active = ra;
		it.requested_mode = q;
		it.is_local_class = cl;
		return it;
	endfunction

	function automatic step_row_t free_row(item_t it);
		step_row_t s;
		s.stim = it;
		s.pinned = 1'b0;
		s.want = '0;
		return s;
	endfunction

	function automatic step_row_t pinned_row(item_t it, result_t want);
		step_row_t s;
		s.stim = it;
		s.pinned = 1'b1;
		s.want = want;
		return s;
	endfunction

	// idle end steps as the largest share, with admissions and mode commands mixed in, so
	// implicit modes get entered and then time out under small thresholds
	function automatic item_t random_item();
		item_t it;
		int roll;
		roll = $urandom_range(99);
		if (roll < 12)
			it.command = CMD_BEGIN_STEP;
		else if (roll < 52)
			it.command = CMD_END_STEP;
		else if (roll < 67)
			it.command = CMD_SET_MODE;
		else
			it.command = CMD_ADMIT;
		it.manual_engaged = ($urandom_range(99) < 30);
		it.local_active = ($urandom_range(99) < 25);
		it.remote_active = ($urandom_range(99) < 25);
		it.requested_mode = mode_t'($urandom_range(3));
		it.is_local_class = 1'($urandom_range(1));
		return it;
	endfunction

	initial begin
		step_row_t plan[$];
		logic [15:0] revert_set[PHASES] = '{16'd0, 16'd1, 16'd3, 16'hffff, 16'd2, 16'd50};
		logic allow_set[PHASES] = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1};
		logic fail_set[PHASES] = '{1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0};

		// admission before the first begin step acts on the standby reset mode
		plan.push_back(pinned_row(mk(CMD_ADMIT, 1'b0, 1'b0, 1'b0, MODE_MANUAL, 1'b1),
			'{authority_epoch: '0, reject_remote: 1'b0, reject_local: 1'b0,
			would_admit_remote: 1'b1, would_admit_local: 1'b1, admitted: 1'b1,
			command_accepted: 1'b0, mode_changed: 1'b1, current_mode: MODE_AUTONOMOUS}));
		// first begin step with manual engaged: announced, epoch stays
		plan.push_back(pinned_row(mk(CMD_BEGIN_STEP, 1'b1, 1'b0, 1'b0, MODE_MANUAL, 1'b0),
			'{authority_epoch: '0, reject_remote: 1'b1, reject_local: 1'b1,
			would_admit_remote: 1'b0, would_admit_local: 1'b0, admitted: 1'b0,
			command_accepted: 1'b0, mode_changed: 1'b1, current_mode: MODE_MANUAL}));
		// mode command while in manual is refused
		plan.push_back(pinned_row(mk(CMD_SET_MODE, 1'b0, 1'b0, 1'b0, MODE_REMOTE, 1'b0),
			'{authority_epoch: '0, reject_remote: 1'b1, reject_local: 1'b1,
			would_admit_remote: 1'b0, would_admit_local: 1'b0, admitted: 1'b0,
			command_accepted: 1'b0, mode_changed: 1'b0, current_mode: MODE_MANUAL}));
		// admission and end step in manual change nothing
		plan.push_back(free_row(mk(CMD_ADMIT, 1'b0, 1'b0, 1'b0, MODE_MANUAL, 1'b1)));
		plan.push_back(free_row(mk(CMD_END_STEP, 1'b0, 1'b1, 1'b1, MODE_MANUAL, 1'b0)));
		// manual released
		plan.push_back(free_row(mk(CMD_BEGIN_STEP, 1'b0, 1'b0, 1'b0, MODE_MANUAL, 1'b0)));
		// request for manual by command is refused
		plan.push_back(pinned_row(mk(CMD_SET_MODE, 1'b0, 1'b0, 1'b0, MODE_MANUAL, 1'b0),
			'{authority_epoch: '0, reject_remote: 1'b0, reject_local: 1'b0,
			would_admit_remote: 1'b1, would_admit_local: 1'b1, admitted: 1'b0,
			command_accepted: 1'b0, mode_changed: 1'b0, current_mode: MODE_STANDBY}));
		// re-assertion of the same mode still bumps the epoch
		plan.push_back(free_row(mk(CMD_SET_MODE, 1'b0, 1'b0, 1'b0, MODE_STANDBY, 1'b0)));
		plan.push_back(free_row(mk(CMD_SET_MODE, 1'b0, 1'b0, 1'b0, MODE_AUTONOMOUS, 1'b0)));
		// explicit entry never times out
		plan.push_back(free_row(mk(CMD_END_STEP, 1'b0, 1'b0, 1'b0, MODE_MANUAL, 1'b0)));
		// remote class in autonomous switches to remote implicitly
		plan.push_back(free_row(mk(CMD_ADMIT, 1'b0, 1'b0, 1'b0, MODE_MANUAL, 1'b0)));
		plan.push_back(free_row(mk(CMD_END_STEP, 1'b0, 1'b0, 1'b1, MODE_MANUAL, 1'b0)));
		plan.push_back(free_row(mk(CMD_END_STEP, 1'b0, 1'b1, 1'b0, MODE_MANUAL, 1'b0)));
		plan.push_back(free_row(mk(CMD_END_STEP, 1'b0, 1'b0, 1'b0, MODE_MANUAL, 1'b0)));
		// local class held in remote, remote class admitted
		plan.push_back(free_row(mk(CMD_ADMIT, 1'b0, 1'b0, 1'b0, MODE_MANUAL, 1'b1)));
		plan.push_back(free_row(mk(CMD_ADMIT, 1'b0, 1'b0, 1'b0, MODE_MANUAL, 1'b0)));
		// manual engaged from remote bumps the epoch, repeat does nothing
		plan.push_back(free_row(mk(CMD_BEGIN_STEP, 1'b1, 1'b0, 1'b0, MODE_MANUAL, 1'b0)));
		plan.push_back(free_row(mk(CMD_BEGIN_STEP, 1'b1, 1'b0, 1'b0, MODE_MANUAL, 1'b0)));
		plan.push_back(free_row(mk(CMD_BEGIN_STEP, 1'b0, 1'b0, 1'b0, MODE_MANUAL, 1'b0)));
		plan.push_back(free_row(mk(CMD_ADMIT, 1'b0, 1'b0, 1'b0, MODE_MANUAL, 1'b1)));
		// only local activity keeps autonomous busy
		plan.push_back(free_row(mk(CMD_END_STEP, 1'b0, 1'b1, 1'b0, MODE_MANUAL, 1'b0)));
		plan.push_back(free_row(mk(CMD_END_STEP, 1'b0, 1'b0, 1'b1, MODE_MANUAL, 1'b0)));
		plan.push_back(free_row(mk(CMD_SET_MODE, 1'b0, 1'b0, 1'b0, MODE_REMOTE, 1'b0)));
		// every field bit high
		plan.push_back(free_row(mk(CMD_END_STEP, 1'b1, 1'b1, 1'b1, MODE_AUTONOMOUS, 1'b1)));
		plan.push_back(free_row(mk(CMD_ADMIT, 1'b1, 1'b1, 1'b1, MODE_AUTONOMOUS, 1'b1)));

		// reset once, then release on a rising edge
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part under reset configuration
		send_gap_pct = 30;
		recv_stall_pct = 53;
		foreach (plan[i])
			offer(plan[i].stim, plan[i].pinned, plan[i].want);
		drain();

		// random phases, each with its own register setting
		for (int p = 0; p < PHASES; p++) begin
			write_reg(REG_IDLE_REVERT, revert_set[p]);
			write_reg(REG_ALLOW_IMPLICIT, {15'd0, allow_set[p]} | 16'(16'hfffe * p[0]));
			write_reg(REG_OUT_OF_MODE, {15'd0, fail_set[p]});
			if (p == 0)
				write_reg(REG_UNUSED, 16'($urandom()));
			cfg_we <= 1'b0;
			@(posedge clk);
			case (p / 2)
				0: begin
					send_gap_pct = 30;
					recv_stall_pct = 53;
				end
				1: begin
					send_gap_pct = 53;
					recv_stall_pct = 30;
				end
				default: begin
					send_gap_pct = 0;
					recv_stall_pct = 0;
				end
			endcase
			if (p == 2 || p == 4)
				hold_req++;
			for (int n = 0; n < ITEMS_PER_PHASE; n++)
				offer(random_item(), 1'b0, '0);
			drain();
		end

		repeat (8) @(posedge clk);
		if (err_count == 0)
			$display("command_authority_mode_manager_top test passed");
		else
			$display("command_authority_mode_manager_top test failed");
		$finish;
	end

endmodule
